### sv/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg: shared definitions of the pulse beat detector
// Register indexes, filter coefficients, field widths and the stage load
// enables that the pipeline control hands to each datapath module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned CoefW   = 13;
  localparam int unsigned ProdW   = 30;
  localparam int unsigned SumW    = 34;
  localparam int unsigned DcShift = 4;
  localparam int unsigned EstLsb  = 15;
  localparam int unsigned AcLsb   = 15;
  localparam int unsigned FirTaps = 23;
  localparam int unsigned FirCoefs = 12;
  localparam int unsigned FirCentre = 11;

  localparam logic [CoefW-1:0] LP_COEF [FirCoefs] = '{
    13'd172, 13'd321, 13'd579, 13'd927, 13'd1360, 13'd1858,
    13'd2390, 13'd2916, 13'd3391, 13'd3768, 13'd4012, 13'd4096
  };

  localparam logic CFG_MIN_SWING = 1'b0;
  localparam logic CFG_MAX_SWING = 1'b1;

  localparam logic [SampleW-1:0] MIN_SWING_RST = 16'd20;
  localparam logic [SampleW-1:0] MAX_SWING_RST = 16'd1000;

  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
    logic ld_s4;
  } stage_en_t;

endpackage

`default_nettype wire

### sv/pbd_in_if.sv
// ----------------------------------------------------------------------------
// pbd_in_if: sample request channel
// Carries one raw optical sample per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pbd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

### sv/pbd_out_if.sv
// ----------------------------------------------------------------------------
// pbd_out_if: result request channel
// Carries the beat flag, the filtered AC value and the DC estimate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pbd_out_if;
  logic               valid;
  logic               ready;
  logic               beat;
  logic signed [15:0] ac_value;
  logic signed [15:0] dc_estimate;

  modport source (output valid, output beat, output ac_value, output dc_estimate,
                  input ready);
  modport sink (input valid, input beat, input ac_value, input dc_estimate,
                output ready);
endinterface

`default_nettype wire

### sv/pbd_dc_est.sv
// ----------------------------------------------------------------------------
// pbd_dc_est: input register and DC estimator
// Holds the accepted sample, runs the leaky accumulator and produces the
// DC estimate and the DC-free sample that enters the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbd_dc_est (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  pbd_pkg::stage_en_t                      en_i,
  input  wire        [pbd_pkg::SampleW-1:0]       sample_i,
  output logic       [pbd_pkg::SampleW-1:0]       ac_in_o,
  output logic signed [pbd_pkg::SampleW-1:0]      est_o
);

  logic        [pbd_pkg::SampleW-1:0] sample_q;
  logic signed [pbd_pkg::AccW-1:0]    acc_q, acc_d;
  logic signed [pbd_pkg::SumW-1:0]    acc_ext, x_ext, step;
  logic signed [pbd_pkg::SampleW-1:0] est_d, est_q;

  always_comb begin
    acc_ext = pbd_pkg::SumW'(acc_q);
    x_ext   = $signed({3'b000, sample_q, 15'd0});
    step    = (x_ext - acc_ext) >>> pbd_pkg::DcShift;
    acc_d   = acc_q + step[pbd_pkg::AccW-1:0];
    est_d   = acc_d[pbd_pkg::EstLsb +: pbd_pkg::SampleW];
  end

  assign ac_in_o = sample_q - est_d;
  assign est_o   = est_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i.ld_s2) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_s1) begin
      sample_q <= sample_i;
    end
    if (en_i.ld_s2) begin
      est_q <= est_d;
    end
  end

endmodule

`default_nettype wire

### sv/pbd_fir.sv
// ----------------------------------------------------------------------------
// pbd_fir: symmetric low-pass filter
// A shift line of the last 23 DC-free samples, a registered row of pair
// products and the sum that gives the AC value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbd_fir (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  pbd_pkg::stage_en_t                 en_i,
  input  wire        [pbd_pkg::SampleW-1:0]  ac_in_i,
  output logic signed [pbd_pkg::SampleW-1:0] ac_o
);

  logic        [pbd_pkg::SampleW-1:0] taps_q [pbd_pkg::FirTaps];
  logic signed [pbd_pkg::ProdW-1:0]   prod_d [pbd_pkg::FirCoefs];
  logic signed [pbd_pkg::ProdW-1:0]   prod_q [pbd_pkg::FirCoefs];
  logic signed [pbd_pkg::SampleW-1:0] pair   [pbd_pkg::FirCoefs];
  logic signed [pbd_pkg::CoefW:0]     coef   [pbd_pkg::FirCoefs];
  logic signed [pbd_pkg::SumW-1:0]    sum;

  always_comb begin
    for (int i = 0; i < pbd_pkg::FirCoefs; i++) begin
      coef[i] = $signed({1'b0, pbd_pkg::LP_COEF[i]});
      if (i == pbd_pkg::FirCentre) begin
        pair[i] = $signed(taps_q[i]);
      end else begin
        pair[i] = $signed(taps_q[i] + taps_q[pbd_pkg::FirTaps-1-i]);
      end
      prod_d[i] = coef[i] * pair[i];
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < pbd_pkg::FirCoefs; i++) begin
      sum = sum + pbd_pkg::SumW'(prod_q[i]);
    end
  end

  assign ac_o = sum[pbd_pkg::AcLsb +: pbd_pkg::SampleW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pbd_pkg::FirTaps; i++) begin
        taps_q[i] <= '0;
      end
    end else if (en_i.ld_s2) begin
      taps_q[0] <= ac_in_i;
      for (int i = 1; i < pbd_pkg::FirTaps; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_s3) begin
      for (int i = 0; i < pbd_pkg::FirCoefs; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

endmodule

`default_nettype wire

### sv/pbd_beat.sv
// ----------------------------------------------------------------------------
// pbd_beat: zero-crossing beat detector and result register
// Tracks peak and trough between crossings of the AC value and flags a beat
// on a rising crossing whose swing lies between the two thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbd_beat (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  pbd_pkg::stage_en_t                 en_i,
  input  wire        [pbd_pkg::SampleW-1:0]  min_swing_i,
  input  wire        [pbd_pkg::SampleW-1:0]  max_swing_i,
  input  wire signed [pbd_pkg::SampleW-1:0]  ac_i,
  input  wire signed [pbd_pkg::SampleW-1:0]  est_i,
  output logic                               beat_o,
  output logic signed [pbd_pkg::SampleW-1:0] ac_o,
  output logic signed [pbd_pkg::SampleW-1:0] est_o
);

  logic signed [pbd_pkg::SampleW-1:0] last_q, peak_q, peak_d, trough_q, trough_d;
  logic signed [pbd_pkg::SampleW-1:0] peak_mid, trough_mid;
  logic                               rising_q, rising_d, falling_q, falling_d;
  logic                               rise, fall, beat_d;
  logic signed [pbd_pkg::SampleW+1:0] swing, min_ext, max_ext;

  always_comb begin
    rise    = last_q[pbd_pkg::SampleW-1] && !ac_i[pbd_pkg::SampleW-1];
    fall    = (last_q > 0) && (ac_i <= 0);
    swing   = $signed({{2{peak_q[pbd_pkg::SampleW-1]}}, peak_q})
              - $signed({{2{trough_q[pbd_pkg::SampleW-1]}}, trough_q});
    min_ext = $signed({2'b00, min_swing_i});
    max_ext = $signed({2'b00, max_swing_i});
    beat_d  = rise && (swing > min_ext) && (swing < max_ext);

    rising_d   = rising_q;
    falling_d  = falling_q;
    peak_mid   = peak_q;
    trough_mid = trough_q;
    if (rise) begin
      rising_d  = 1'b1;
      falling_d = 1'b0;
      peak_mid  = '0;
    end
    if (fall) begin
      rising_d   = 1'b0;
      falling_d  = 1'b1;
      trough_mid = '0;
    end
    peak_d   = (rising_d && (ac_i > last_q)) ? ac_i : peak_mid;
    trough_d = (falling_d && (ac_i < last_q)) ? ac_i : trough_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      peak_q    <= '0;
      trough_q  <= '0;
      rising_q  <= 1'b0;
      falling_q <= 1'b0;
    end else if (en_i.ld_s4) begin
      last_q    <= ac_i;
      peak_q    <= peak_d;
      trough_q  <= trough_d;
      rising_q  <= rising_d;
      falling_q <= falling_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_s4) begin
      beat_o <= beat_d;
      ac_o   <= ac_i;
      est_o  <= est_i;
    end
  end

endmodule

`default_nettype wire

### sv/pulse_beat_detector_core.sv
// ----------------------------------------------------------------------------
// pulse_beat_detector_core: optical pulse beat detector
// Removes the DC level from raw optical samples, low-pass filters the rest
// and flags heartbeats at rising zero crossings of the filtered signal.
//
// Samples arrive on in_ch and results leave on out_ch; both use valid/ready
// and a request moves at a rising edge with valid and ready high. Each
// sample yields exactly one result: the beat flag, the AC value and the DC
// estimate. The datapath is four registered stages (input register, DC
// estimator with the filter shift line, pair products, sum with beat
// detection and result register), and each sample passes through them in
// that order. One sample is taken every cycle while results drain.
// The swing thresholds are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while no request is in
// flight, as the block itself does not enforce it. Reset empties the
// pipeline, zeroes the accumulator, shift line and crossing tracker, and
// restores the thresholds to 20 and 1000. When the receiver stalls, each
// stage holds its request; bubbles are squeezed out and in_ch.ready falls
// once all four stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pulse_beat_detector_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  pbd_in_if.sink                       in_ch,
  pbd_out_if.source                    out_ch,
  input  wire                          cfg_we_i,
  input  wire                          cfg_idx_i,
  input  wire [pbd_pkg::SampleW-1:0]   cfg_data_i
);

  logic                               v1_q, v2_q, v3_q, v4_q;
  logic                               take1, take2, take3, take4;
  pbd_pkg::stage_en_t                 en;
  logic [pbd_pkg::SampleW-1:0]        min_swing_q, max_swing_q;
  logic [pbd_pkg::SampleW-1:0]        ac_in;
  logic signed [pbd_pkg::SampleW-1:0] est_s2, est_s3_q, ac_s3;

  always_comb begin
    take4 = !v4_q || out_ch.ready;
    take3 = !v3_q || take4;
    take2 = !v2_q || take3;
    take1 = !v1_q || take2;
    en.ld_s1 = take1 && in_ch.valid;
    en.ld_s2 = take2 && v1_q;
    en.ld_s3 = take3 && v2_q;
    en.ld_s4 = take4 && v3_q;
  end

  assign in_ch.ready  = take1;
  assign out_ch.valid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      min_swing_q <= pbd_pkg::MIN_SWING_RST;
      max_swing_q <= pbd_pkg::MAX_SWING_RST;
    end else begin
      if (take1) begin
        v1_q <= in_ch.valid;
      end
      if (take2) begin
        v2_q <= v1_q;
      end
      if (take3) begin
        v3_q <= v2_q;
      end
      if (take4) begin
        v4_q <= v3_q;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pbd_pkg::CFG_MIN_SWING: min_swing_q <= cfg_data_i;
          pbd_pkg::CFG_MAX_SWING: max_swing_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.ld_s3) begin
      est_s3_q <= est_s2;
    end
  end

  pbd_dc_est u_dc_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .sample_i (in_ch.sample),
    .ac_in_o  (ac_in),
    .est_o    (est_s2)
  );

  pbd_fir u_fir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ac_in_i (ac_in),
    .ac_o    (ac_s3)
  );

  pbd_beat u_beat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .min_swing_i (min_swing_q),
    .max_swing_i (max_swing_q),
    .ac_i        (ac_s3),
    .est_i       (est_s3_q),
    .beat_o      (out_ch.beat),
    .ac_o        (out_ch.ac_value),
    .est_o       (out_ch.dc_estimate)
  );

endmodule

`default_nettype wire
